// ----- rtl/cgc_pkg.sv -----
`timescale 1ns / 1ps
package cgc_pkg;

    localparam int ACC_W    = 96;
    localparam int OPX_W    = 34;
    localparam int QUO_W    = 64;
    localparam int T_W      = 35;
    localparam int ROOT_W   = 32;
    localparam int SQ_REM_W = 35;
    localparam int DCNT_W   = 8;
    localparam int SCNT_W   = 6;
    localparam int SEL_W    = 5;

    // Term divide: numerator is the full factorial; final divide appends 62 fraction bits
    localparam logic [DCNT_W-1:0] DIV_STEPS_TERM  = 8'd96;
    localparam logic [DCNT_W-1:0] DIV_STEPS_FINAL = 8'd158;
    localparam logic [SCNT_W-1:0] SQRT_STEPS      = 6'd32;

    localparam logic [SEL_W-1:0] SEL_K0    = 5'd0;
    localparam logic [SEL_W-1:0] SEL_K1    = 5'd1;
    localparam logic [SEL_W-1:0] SEL_K2    = 5'd2;
    localparam logic [SEL_W-1:0] SEL_K3    = 5'd3;
    localparam logic [SEL_W-1:0] SEL_K4    = 5'd4;
    localparam logic [SEL_W-1:0] SEL_K5    = 5'd5;
    localparam logic [SEL_W-1:0] SEL_FA    = 5'd6;
    localparam logic [SEL_W-1:0] SEL_FB    = 5'd7;
    localparam logic [SEL_W-1:0] SEL_FC    = 5'd8;
    localparam logic [SEL_W-1:0] SEL_F3P   = 5'd9;
    localparam logic [SEL_W-1:0] SEL_F3M   = 5'd10;
    localparam logic [SEL_W-1:0] SEL_F2P   = 5'd11;
    localparam logic [SEL_W-1:0] SEL_F2M   = 5'd12;
    localparam logic [SEL_W-1:0] SEL_F1P   = 5'd13;
    localparam logic [SEL_W-1:0] SEL_F1M   = 5'd14;
    localparam logic [SEL_W-1:0] SEL_TMAG0 = 5'd15;
    localparam logic [SEL_W-1:0] SEL_TMAG1 = 5'd16;
    localparam logic [SEL_W-1:0] SEL_MF0   = 5'd17;
    localparam logic [SEL_W-1:0] SEL_MF1   = 5'd18;

    typedef struct packed {
        logic             load_in;
        logic             clr_t;
        logic             r_clr;
        logic             r_inc;
        logic             acc_one;
        logic             acc_pn;
        logic             acc_df;
        logic             mul_go;
        logic [SEL_W-1:0] sel;
        logic             div_go;
        logic             div_final;
        logic             t_upd;
        logic             save_n;
        logic             sqrt_go;
        logic             out_zero;
        logic             out_val;
    } t_cmd;

    typedef struct packed {
        logic invalid;
        logic skip;
        logic r_last;
        logic t_zero;
        logic mul_busy;
        logic div_busy;
        logic sqrt_busy;
    } t_sts;

    function automatic logic [OPX_W-1:0] fact(input logic signed [5:0] v);
        logic [OPX_W-1:0] f;
        case (v)
            6'sd0:   f = 34'd1;
            6'sd1:   f = 34'd1;
            6'sd2:   f = 34'd2;
            6'sd3:   f = 34'd6;
            6'sd4:   f = 34'd24;
            6'sd5:   f = 34'd120;
            6'sd6:   f = 34'd720;
            6'sd7:   f = 34'd5040;
            6'sd8:   f = 34'd40320;
            6'sd9:   f = 34'd362880;
            6'sd10:  f = 34'd3628800;
            6'sd11:  f = 34'd39916800;
            6'sd12:  f = 34'd479001600;
            6'sd13:  f = 34'd6227020800;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

// ----- rtl/cgc_datapath.sv -----
`timescale 1ns / 1ps
module cgc_datapath import cgc_pkg::*; #(
    parameter int J_MAX = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [1:0]          i_j_first,
    input  logic signed [2:0]   i_m_first,
    input  logic [1:0]          i_j_second,
    input  logic signed [2:0]   i_m_second,
    input  logic [2:0]          i_j_total,
    input  logic signed [3:0]   i_m_total,
    output logic                o_valid,
    output logic signed [31:0]  o_coefficient_value
);

    logic [1:0]          r_j1, r_j2;
    logic [2:0]          r_j3;
    logic signed [2:0]   r_m1, r_m2;
    logic signed [3:0]   r_m3;
    logic [2:0]          r_r;

    logic [ACC_W-1:0]    r_acc, r_mcand, r_num, r_dv, r_dvd, r_rem;
    logic [OPX_W-1:0]    r_mx;
    logic                r_mul_run, r_div_run, r_sq_run;
    logic [QUO_W-1:0]    r_quo, r_sq_src;
    logic [DCNT_W-1:0]   r_dcnt;
    logic signed [T_W-1:0] r_t;
    logic [SQ_REM_W-1:0] r_sq_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [SCNT_W-1:0]   r_scnt;
    logic                r_vld;
    logic signed [31:0]  r_out;

    logic signed [5:0] s_j1, s_j2, s_j3, s_m1, s_m2, s_m3, s_r;
    logic signed [5:0] s_a, s_b, s_c, s_f;
    logic signed [5:0] k0, k1, k2, k3, k4, k5;
    logic [OPX_W-1:0]  mfull, opx, tmag;
    logic              bad_j, bad_m;
    logic [ACC_W:0]    trial, diff;
    logic              div_ge;
    logic [SQ_REM_W-1:0] sq_rem2, sq_trial;
    logic              sq_ge;
    logic [31:0]       kval;
    logic [T_W-1:0]    t_abs;

    always_comb begin
        s_j1 = $signed({4'b0, r_j1});
        s_j2 = $signed({4'b0, r_j2});
        s_j3 = $signed({3'b0, r_j3});
        s_m1 = {{3{r_m1[2]}}, r_m1};
        s_m2 = {{3{r_m2[2]}}, r_m2};
        s_m3 = {{2{r_m3[3]}}, r_m3};
        s_r  = $signed({3'b0, r_r});
        s_a  = s_j1 + s_j2 - s_j3;
        s_b  = s_j1 - s_j2 + s_j3;
        s_c  = s_j2 - s_j1 + s_j3;
        s_f  = s_j1 + s_j2 + s_j3;
        k0   = s_r;
        k1   = s_a - s_r;
        k2   = s_j1 + s_m1 - s_r;
        k3   = s_j3 - s_j1 + s_m2 + s_r;
        k4   = s_j3 - s_m1 - s_j2 + s_r;
        k5   = s_j2 - s_m2 - s_r;
        bad_j = (s_j1 > $signed(6'(J_MAX))) || (s_j2 > $signed(6'(J_MAX)))
             || (s_j3 > $signed(6'(2 * J_MAX)));
        bad_m = (s_m1 + s_m2 != s_m3)
             || (s_j1 - s_m1 < 0) || (s_j1 + s_m1 < 0)
             || (s_j2 - s_m2 < 0) || (s_j2 + s_m2 < 0)
             || (s_j3 - s_m3 < 0) || (s_j3 + s_m3 < 0);
        mfull = fact(s_f);
        t_abs = r_t[T_W-1] ? T_W'(-r_t) : T_W'(r_t);
        tmag  = t_abs[OPX_W-1:0];
        case (i_cmd.sel)
            SEL_K0:    opx = fact(k0);
            SEL_K1:    opx = fact(k1);
            SEL_K2:    opx = fact(k2);
            SEL_K3:    opx = fact(k3);
            SEL_K4:    opx = fact(k4);
            SEL_K5:    opx = fact(k5);
            SEL_FA:    opx = fact(s_a);
            SEL_FB:    opx = fact(s_b);
            SEL_FC:    opx = fact(s_c);
            SEL_F3P:   opx = fact(s_j3 + s_m3);
            SEL_F3M:   opx = fact(s_j3 - s_m3);
            SEL_F2P:   opx = fact(s_j2 + s_m2);
            SEL_F2M:   opx = fact(s_j2 - s_m2);
            SEL_F1P:   opx = fact(s_j1 + s_m1);
            SEL_F1M:   opx = fact(s_j1 - s_m1);
            SEL_TMAG0: opx = tmag;
            SEL_TMAG1: opx = tmag;
            SEL_MF0:   opx = mfull;
            SEL_MF1:   opx = mfull;
            default:   opx = '0;
        endcase

        trial  = {r_rem, r_dvd[ACC_W-1]};
        diff   = trial - {1'b0, r_dv};
        div_ge = (trial >= {1'b0, r_dv});

        sq_rem2  = {r_sq_rem[SQ_REM_W-3:0], r_sq_src[QUO_W-1 -: 2]};
        sq_trial = {1'b0, r_root, 2'b01};
        sq_ge    = (sq_rem2 >= sq_trial);
        kval     = 32'(({1'b0, r_root} + 33'd1) >> 1);

        o_sts.invalid   = bad_j || bad_m || (s_a < 0) || (s_b < 0) || (s_c < 0);
        o_sts.skip      = (k0 < 0) || (k1 < 0) || (k2 < 0) || (k3 < 0) || (k4 < 0)
                       || (k5 < 0);
        o_sts.r_last    = (s_r == s_a);
        o_sts.t_zero    = (r_t == '0);
        o_sts.mul_busy  = r_mul_run;
        o_sts.div_busy  = r_div_run;
        o_sts.sqrt_busy = r_sq_run;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_j1 <= i_j_first;
            r_m1 <= i_m_first;
            r_j2 <= i_j_second;
            r_m2 <= i_m_second;
            r_j3 <= i_j_total;
            r_m3 <= i_m_total;
        end
        if (i_cmd.r_clr) begin
            r_r <= '0;
        end else if (i_cmd.r_inc) begin
            r_r <= r_r + 3'd1;
        end
        if (i_cmd.clr_t) begin
            r_t <= '0;
        end else if (i_cmd.t_upd) begin
            // odd r+a gives a negative term
            if (r_r[0] ^ s_a[0]) begin
                r_t <= r_t - $signed(T_W'(r_quo[OPX_W-1:0]));
            end else begin
                r_t <= r_t + $signed(T_W'(r_quo[OPX_W-1:0]));
            end
        end
        if (i_cmd.save_n) begin
            r_num <= r_acc;
        end

        // shift-add multiplier, one multiplier bit a cycle
        if (i_cmd.acc_one) begin
            r_acc <= ACC_W'(1);
        end else if (i_cmd.acc_pn) begin
            r_acc <= ACC_W'({r_j3, 1'b1});
        end else if (i_cmd.acc_df) begin
            r_acc <= ACC_W'(fact(s_f + 6'sd1));
        end else if (i_cmd.mul_go) begin
            r_mcand <= r_acc;
            r_acc   <= '0;
            r_mx    <= opx;
        end else if (r_mul_run && (r_mx != '0)) begin
            if (r_mx[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand <= r_mcand << 1;
            r_mx    <= r_mx >> 1;
        end

        // restoring divider, one quotient bit a cycle
        if (i_cmd.div_go) begin
            r_dv   <= r_acc;
            r_dvd  <= i_cmd.div_final ? r_num : ACC_W'(mfull);
            r_rem  <= '0;
            r_quo  <= '0;
            r_dcnt <= i_cmd.div_final ? DIV_STEPS_FINAL : DIV_STEPS_TERM;
        end else if (r_div_run && (r_dcnt != '0)) begin
            r_rem  <= div_ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
            r_quo  <= {r_quo[QUO_W-2:0], div_ge};
            r_dvd  <= r_dvd << 1;
            r_dcnt <= r_dcnt - DCNT_W'(1);
        end

        // digit-by-digit square root, two radicand bits a cycle
        if (i_cmd.sqrt_go) begin
            r_sq_src <= r_quo;
            r_sq_rem <= '0;
            r_root   <= '0;
            r_scnt   <= SQRT_STEPS;
        end else if (r_sq_run && (r_scnt != '0)) begin
            r_sq_rem <= sq_ge ? sq_rem2 - sq_trial : sq_rem2;
            r_root   <= {r_root[ROOT_W-2:0], sq_ge};
            r_sq_src <= r_sq_src << 2;
            r_scnt   <= r_scnt - SCNT_W'(1);
        end

        if (i_cmd.out_zero) begin
            r_out <= '0;
        end else if (i_cmd.out_val) begin
            r_out <= r_t[T_W-1] ? -$signed(kval) : $signed(kval);
        end

        if (!i_rst_n) begin
            r_mul_run <= 1'b0;
            r_div_run <= 1'b0;
            r_sq_run  <= 1'b0;
            r_vld     <= 1'b0;
        end else begin
            if (i_cmd.mul_go) begin
                r_mul_run <= 1'b1;
            end else if (r_mul_run && (r_mx == '0)) begin
                r_mul_run <= 1'b0;
            end
            if (i_cmd.div_go) begin
                r_div_run <= 1'b1;
            end else if (r_div_run && (r_dcnt == '0)) begin
                r_div_run <= 1'b0;
            end
            if (i_cmd.sqrt_go) begin
                r_sq_run <= 1'b1;
            end else if (r_sq_run && (r_scnt == '0)) begin
                r_sq_run <= 1'b0;
            end
            r_vld <= i_cmd.out_zero || i_cmd.out_val;
        end
    end

    assign o_valid             = r_vld;
    assign o_coefficient_value = r_out;

endmodule

// ----- rtl/cgc_ctrl.sv -----
`timescale 1ns / 1ps
module cgc_ctrl import cgc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHK   = 4'd1;
    localparam logic [3:0] ST_TERM  = 4'd2;
    localparam logic [3:0] ST_TMUL  = 4'd3;
    localparam logic [3:0] ST_TMW   = 4'd4;
    localparam logic [3:0] ST_TDIV  = 4'd5;
    localparam logic [3:0] ST_TDW   = 4'd6;
    localparam logic [3:0] ST_PSEED = 4'd7;
    localparam logic [3:0] ST_PMUL  = 4'd8;
    localparam logic [3:0] ST_PMW   = 4'd9;
    localparam logic [3:0] ST_DMUL  = 4'd10;
    localparam logic [3:0] ST_DMW   = 4'd11;
    localparam logic [3:0] ST_FDIV  = 4'd12;
    localparam logic [3:0] ST_FDW   = 4'd13;
    localparam logic [3:0] ST_SQ    = 4'd14;
    localparam logic [3:0] ST_SQW   = 4'd15;

    logic [3:0]       r_state, n_state;
    logic [SEL_W-1:0] r_sel, n_sel;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.sel = r_sel;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load_in = 1'b1;
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (i_sts.invalid) begin
                    o_cmd.out_zero = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.clr_t = 1'b1;
                    o_cmd.r_clr = 1'b1;
                    n_state = ST_TERM;
                end
            end
            ST_TERM: begin
                if (i_sts.skip) begin
                    if (i_sts.r_last) begin
                        n_state = ST_PSEED;
                    end else begin
                        o_cmd.r_inc = 1'b1;
                    end
                end else begin
                    o_cmd.acc_one = 1'b1;
                    n_sel   = SEL_K0;
                    n_state = ST_TMUL;
                end
            end
            ST_TMUL: begin
                o_cmd.mul_go = 1'b1;
                n_state = ST_TMW;
            end
            ST_TMW: begin
                if (!i_sts.mul_busy) begin
                    if (r_sel == SEL_K5) begin
                        n_state = ST_TDIV;
                    end else begin
                        n_sel   = r_sel + SEL_W'(1);
                        n_state = ST_TMUL;
                    end
                end
            end
            ST_TDIV: begin
                o_cmd.div_go = 1'b1;
                n_state = ST_TDW;
            end
            ST_TDW: begin
                if (!i_sts.div_busy) begin
                    o_cmd.t_upd = 1'b1;
                    if (i_sts.r_last) begin
                        n_state = ST_PSEED;
                    end else begin
                        o_cmd.r_inc = 1'b1;
                        n_state = ST_TERM;
                    end
                end
            end
            ST_PSEED: begin
                if (i_sts.t_zero) begin
                    o_cmd.out_zero = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.acc_pn = 1'b1;
                    n_sel   = SEL_FA;
                    n_state = ST_PMUL;
                end
            end
            ST_PMUL: begin
                o_cmd.mul_go = 1'b1;
                n_state = ST_PMW;
            end
            ST_PMW: begin
                if (!i_sts.mul_busy) begin
                    if (r_sel == SEL_TMAG1) begin
                        // keep the numerator, seed the denominator
                        o_cmd.save_n = 1'b1;
                        o_cmd.acc_df = 1'b1;
                        n_sel   = SEL_MF0;
                        n_state = ST_DMUL;
                    end else begin
                        n_sel   = r_sel + SEL_W'(1);
                        n_state = ST_PMUL;
                    end
                end
            end
            ST_DMUL: begin
                o_cmd.mul_go = 1'b1;
                n_state = ST_DMW;
            end
            ST_DMW: begin
                if (!i_sts.mul_busy) begin
                    if (r_sel == SEL_MF1) begin
                        n_state = ST_FDIV;
                    end else begin
                        n_sel   = r_sel + SEL_W'(1);
                        n_state = ST_DMUL;
                    end
                end
            end
            ST_FDIV: begin
                o_cmd.div_go    = 1'b1;
                o_cmd.div_final = 1'b1;
                n_state = ST_FDW;
            end
            ST_FDW: begin
                if (!i_sts.div_busy) begin
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                o_cmd.sqrt_go = 1'b1;
                n_state = ST_SQW;
            end
            ST_SQW: begin
                if (!i_sts.sqrt_busy) begin
                    o_cmd.out_val = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sel   <= SEL_K0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    assign busy = (r_state != ST_IDLE);

endmodule

// ----- rtl/clebsch_gordan_coefficient.sv -----
`timescale 1ns / 1ps
// A result that is zero by a selection rule is decided in the check state; otherwise the
// run time is set by the shift-add multiplier (one operand bit a cycle), the restoring
// divider (96 steps per Racah term, 158 for the final ratio) and the 32-step square root.
// One item at a time: busy is high until the result word.
// The result word is shown on o_valid for one cycle; the receiver cannot stall.
// Reset (i_rst_n low, synchronous) returns the controller to idle and drops o_valid.
module clebsch_gordan_coefficient import cgc_pkg::*; #(
    parameter int J_MAX = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_j_first,
    input  logic signed [2:0]  i_m_first,
    input  logic [1:0]         i_j_second,
    input  logic signed [2:0]  i_m_second,
    input  logic [2:0]         i_j_total,
    input  logic signed [3:0]  i_m_total,
    output logic               o_valid,
    output logic signed [31:0] o_coefficient_value
);

    t_cmd cmd;
    t_sts sts;

    cgc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cgc_datapath #(
        .J_MAX (J_MAX)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_j_first           (i_j_first),
        .i_m_first           (i_m_first),
        .i_j_second          (i_j_second),
        .i_m_second          (i_m_second),
        .i_j_total           (i_j_total),
        .i_m_total           (i_m_total),
        .o_valid             (o_valid),
        .o_coefficient_value (o_coefficient_value)
    );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import cgc_pkg::*;

    localparam longint CYCLE_LIMIT = 8000000;

    class coeff_scoreboard;
        int expected_coeffs[$];
        int mismatches;

        function new();
            mismatches = 0;
        endfunction

        function automatic longint unsigned factorial(int v);
            longint unsigned f;
            f = 1;
            if (v < 0 || v > 13) return 0;
            for (int i = 2; i <= v; i++) f = f * i;
            return f;
        endfunction

        // Racah sum in exact integers, then round-to-nearest of 2^30 times the root
        function automatic int racah_coefficient(bit [1:0] j1r, bit signed [2:0] m1r,
                                                 bit [1:0] j2r, bit signed [2:0] m2r,
                                                 bit [2:0] j3r, bit signed [3:0] m3r);
            int j1 = j1r;
            int m1 = m1r;
            int j2 = j2r;
            int m2 = m2r;
            int j3 = j3r;
            int m3 = m3r;
            int a, b, c;
            int k[6];
            bit skip;
            longint t;
            longint unsigned mfull, dr, mag, lo, hi, mid;
            logic [383:0] num, den, tmp;
            t = 0;
            if (j3 > 6) return 0;
            if (m1 + m2 != m3) return 0;
            if (j1 - m1 < 0 || j1 + m1 < 0 || j2 - m2 < 0 || j2 + m2 < 0 ||
                j3 - m3 < 0 || j3 + m3 < 0) return 0;
            a = j1 + j2 - j3;
            b = j1 - j2 + j3;
            c = j2 - j1 + j3;
            if (a < 0 || b < 0 || c < 0) return 0;
            mfull = factorial(j1 + j2 + j3);
            for (int r = 0; r <= a; r++) begin
                k[0] = r; k[1] = a - r; k[2] = j1 + m1 - r;
                k[3] = j3 - j1 + m2 + r; k[4] = j3 - m1 - j2 + r; k[5] = j2 - m2 - r;
                dr = 1;
                skip = 0;
                foreach (k[i]) begin
                    if (k[i] < 0) skip = 1;
                    else dr = dr * factorial(k[i]);
                end
                if (!skip && dr != 0) begin
                    if ((r + a) % 2 != 0) t = t - longint'(mfull / dr);
                    else t = t + longint'(mfull / dr);
                end
            end
            if (t == 0) return 0;
            mag = (t < 0) ? longint'(-t) : t;
            num = 384'(2 * j3 + 1);
            num = num * 384'(factorial(a)) * 384'(factorial(b)) * 384'(factorial(c));
            num = num * 384'(factorial(j3 + m3)) * 384'(factorial(j3 - m3));
            num = num * 384'(factorial(j2 + m2)) * 384'(factorial(j2 - m2));
            num = num * 384'(factorial(j1 + m1)) * 384'(factorial(j1 - m1));
            num = (num * 384'(mag) * 384'(mag)) << 62;
            den = 384'(factorial(j1 + j2 + j3 + 1)) * 384'(mfull) * 384'(mfull);
            lo = 0;
            hi = 64'd1 << 30;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                tmp = den * 384'(2 * mid - 1) * 384'(2 * mid - 1);
                if (tmp <= num) lo = mid;
                else hi = mid - 1;
            end
            return (t < 0) ? -int'(lo) : int'(lo);
        endfunction

        function void note_word(bit [1:0] j1, bit signed [2:0] m1, bit [1:0] j2,
                                bit signed [2:0] m2, bit [2:0] j3, bit signed [3:0] m3);
            expected_coeffs.push_back(racah_coefficient(j1, m1, j2, m2, j3, m3));
        endfunction

        function void check_word(logic signed [31:0] got);
            int want;
            if (expected_coeffs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %0d", got);
                return;
            end
            want = expected_coeffs.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("coefficient mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_j_first;
    logic signed [2:0]  i_m_first;
    logic [1:0]         i_j_second;
    logic signed [2:0]  i_m_second;
    logic [2:0]         i_j_total;
    logic signed [3:0]  i_m_total;
    logic               o_valid;
    logic signed [31:0] o_coefficient_value;

    coeff_scoreboard sb = new();
    longint cycles = 0;
    bit burst_mode = 0;

    clebsch_gordan_coefficient u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_j_first          (i_j_first),
        .i_m_first          (i_m_first),
        .i_j_second         (i_j_second),
        .i_m_second         (i_m_second),
        .i_j_total          (i_j_total),
        .i_m_total          (i_m_total),
        .o_valid            (o_valid),
        .o_coefficient_value(o_coefficient_value)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("clebsch_gordan_coefficient test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_word(o_coefficient_value);
    end

    // hold start high until the word is taken; a zero gap keeps start up for the next word
    task automatic send_word(bit [1:0] j1, bit signed [2:0] m1, bit [1:0] j2,
                             bit signed [2:0] m2, bit [2:0] j3, bit signed [3:0] m3);
        int gap;
        gap = 0;
        if (!burst_mode)
            gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(5, 60);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_j_first  <= j1;
        i_m_first  <= m1;
        i_j_second <= j2;
        i_m_second <= m2;
        i_j_total  <= j3;
        i_m_total  <= m3;
        start      <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_word(j1, m1, j2, m2, j3, m3);
    endtask

    task automatic send_coupled();
        int j1, j2, j3, m1, m2;
        j1 = $urandom_range(0, 3);
        j2 = $urandom_range(0, 3);
        m1 = $urandom_range(0, 2 * j1) - j1;
        m2 = $urandom_range(0, 2 * j2) - j2;
        j3 = $urandom_range((j1 > j2) ? j1 - j2 : j2 - j1, j1 + j2);
        send_word(2'(j1), 3'(m1), 2'(j2), 3'(m2), 3'(j3), 4'(m1 + m2));
    endtask

    initial begin
        int waited;
        i_rst_n    = 0;
        start      = 0;
        i_j_first  = 0;
        i_m_first  = 0;
        i_j_second = 0;
        i_m_second = 0;
        i_j_total  = 0;
        i_m_total  = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(0, 0, 0, 0, 0, 0);
        send_word(3, 3, 3, 3, 6, 6);
        send_word(3, -3, 3, -3, 6, -6);
        send_word(3, 0, 3, 0, 0, 0);
        send_word(1, 1, 1, -1, 1, 0);
        send_word(2, 1, 3, -2, 3, -1);
        send_word(3, 2, 3, -3, 2, -1);
        send_word(1, 1, 1, 1, 1, 1);     // selection rule fails, projections within spins
        send_word(1, 1, 1, 0, 2, 0);     // selection rule fails
        send_word(1, 2, 1, 0, 2, 2);     // projection beyond spin
        send_word(3, 0, 0, 0, 2, 0);     // triangle, below
        send_word(1, 0, 1, 0, 3, 0);     // triangle, above
        send_word(3, -4, 3, 0, 6, -4);   // out-of-range projection code
        send_word(3, 0, 3, 0, 7, 0);     // j_total beyond range
        send_word(3, -4, 3, -4, 6, -8);
        send_word(3, 3, 3, 3, 6, 7);
        send_word(2, 2, 2, -2, 4, 0);
        send_word(3, 1, 2, -1, 1, 0);
        send_word(1, 0, 1, 0, 1, 0);     // cancelling sum

        for (int n = 0; n < 1230; n++) begin
            if ($urandom_range(0, 99) < 3) burst_mode = ~burst_mode;
            if ($urandom_range(0, 9) < 7) send_coupled();
            else send_word(2'($urandom), 3'($urandom), 2'($urandom), 3'($urandom),
                           3'($urandom), 4'($urandom));
        end
        start <= 1'b0;

        waited = 0;
        while (sb.expected_coeffs.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (50) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_coeffs.size() == 0)
            $display("clebsch_gordan_coefficient test passed");
        else
            $display("clebsch_gordan_coefficient test failed");
        $finish;
    end

endmodule
